>>> design/bpc_pkg.sv
// Package with the word types, click codes and register map of the button press classifier.
package bpc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	// Click classification codes.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_IDLE_LEVEL     = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE_DELAY = 2'd1;
	localparam logic [1:0] REG_LONG_PRESS_MS  = 2'd2;

	localparam logic [15:0] HOLD_MAX          = 16'hFFFF;
	localparam logic [15:0] LONG_PRESS_RESET  = 16'd1000;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        button_level;
		logic        restart_hold;
	} item_t;

	typedef struct packed {
		logic        press_edge;
		logic [1:0]  click_kind;
		logic [15:0] hold_ms;
		logic        long_pulse;
	} result_t;

endpackage

>>> design/button_press_classifier.sv
// Top level of the button press classifier: debounce gating, press classification, APB registers.
// Path: a word accepted at the input edge is held in the input stage and then moves to the result
// register, from which it can be taken; a stall on the result port holds it in between.
// Throughput: one word per cycle while the result port is not stalled; the state registers are
// read and rewritten once per word, and that update loop sets the rate.
// Reset (arst_n low, asynchronous): pipeline empty, registers at idle_level 1,
// debounce_delay 0, long_press_ms 1000, and the press state released with zero times.
module button_press_classifier #(
	parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input word channel.
	input  logic                               item_valid,
	output logic                               item_ready,
	input  bpc_pkg::item_t                     item,
	// Result word channel.
	output logic                               result_valid,
	input  logic                               result_ready,
	output bpc_pkg::result_t                   result,
	// APB-style configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bpc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [bpc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [bpc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);
	import bpc_pkg::*;

	// Configuration registers.
	logic        idle_level_q;
	logic [15:0] debounce_delay_q;
	logic [15:0] long_press_ms_q;

	// Press state carried from word to word.
	logic                 prev_released_q;
	logic [TIME_BITS-1:0] last_sample_q;
	logic [TIME_BITS-1:0] hold_start_q;
	logic                 press_armed_q;
	logic                 long_fired_q;

	// Input register stage and result register.
	logic    valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;

	// The whole pipeline moves when the result register is free or being emptied.
	logic advance;
	logic step;

	logic [1:0] reg_index;
	logic       cfg_write;

	// Combinational step signals.
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] since_last;
	logic [TIME_BITS-1:0] since_hold;
	logic [TIME_BITS-1:0] hold_start_mid;
	logic [TIME_BITS-1:0] held_for;
	logic                 released;
	logic                 sample_ok;
	logic                 edge_det;
	logic [1:0]           kind;
	logic                 armed_nx;
	logic                 prev_released_nx;
	logic                 long_fired_mid;
	logic                 holding;
	logic [15:0]          hold;
	logic                 pulse;

	assign advance    = !result_valid_q || result_ready;
	assign step       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// APB access: always ready, writes land on the access phase.
	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		unique case (reg_index)
			REG_IDLE_LEVEL:     prdata = APB_DATA_BITS'(idle_level_q);
			REG_DEBOUNCE_DELAY: prdata = APB_DATA_BITS'(debounce_delay_q);
			REG_LONG_PRESS_MS:  prdata = APB_DATA_BITS'(long_press_ms_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q     <= 1'b1;
			debounce_delay_q <= '0;
			long_press_ms_q  <= LONG_PRESS_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_IDLE_LEVEL:     idle_level_q     <= pwdata[0];
				REG_DEBOUNCE_DELAY: debounce_delay_q <= pwdata[15:0];
				REG_LONG_PRESS_MS:  long_press_ms_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// The timestamp is taken modulo 2^TIME_BITS, so every difference below wraps safely.
	assign now_t      = TIME_BITS'(item_s1.now_ms);
	assign released   = (item_s1.button_level == idle_level_q);
	assign since_last = now_t - last_sample_q;
	assign since_hold = now_t - hold_start_q;
	assign sample_ok  = (since_last >= TIME_BITS'(debounce_delay_q));

	// Classification of an accepted sample. A rejected sample leaves the level state alone.
	always_comb begin
		edge_det = 1'b0;
		kind     = KIND_NONE;
		armed_nx = press_armed_q;
		if (sample_ok) begin
			if (!released && prev_released_q) begin
				edge_det = 1'b1;
				armed_nx = 1'b1;
			end else if (released && !prev_released_q && press_armed_q) begin
				armed_nx = 1'b0;
				kind     = KIND_SHORT;
			end else if (!released && !prev_released_q && press_armed_q) begin
				if (since_hold > TIME_BITS'(long_press_ms_q)) begin
					armed_nx = 1'b0;
					kind     = KIND_LONG;
				end
			end
		end
	end

	// A press edge restarts the hold timer and rearms the long pulse before the hold is read.
	assign prev_released_nx = sample_ok ? released : prev_released_q;
	assign hold_start_mid   = edge_det ? now_t : hold_start_q;
	assign long_fired_mid   = edge_det ? 1'b0 : long_fired_q;
	assign held_for         = now_t - hold_start_mid;
	assign holding          = !released && !prev_released_nx;

	always_comb begin
		hold = '0;
		if (holding) begin
			if (held_for > TIME_BITS'(HOLD_MAX)) begin
				hold = HOLD_MAX;
			end else begin
				hold = held_for[15:0];
			end
		end
	end

	assign pulse = (hold > long_press_ms_q) && !long_fired_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_released_q <= 1'b1;
			last_sample_q   <= '0;
			hold_start_q    <= '0;
			press_armed_q   <= 1'b0;
			long_fired_q    <= 1'b0;
		end else if (step) begin
			prev_released_q <= prev_released_nx;
			press_armed_q   <= armed_nx;
			long_fired_q    <= long_fired_mid || pulse;
			if (sample_ok) begin
				last_sample_q <= now_t;
			end
			// A restart request takes effect after the outputs of this word are formed.
			hold_start_q <= item_s1.restart_hold ? now_t : hold_start_mid;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Result register: holds a finished word while the next one waits in the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.press_edge <= edge_det;
			result_q.click_kind <= kind;
			result_q.hold_ms    <= hold;
			result_q.long_pulse <= pulse;
		end
	end

endmodule

>>> design/bpc_checker.sv
// Port-level checker for the button press classifier and its bind statement.
module bpc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input bpc_pkg::item_t                     item,
	input logic                               result_valid,
	input logic                               result_ready,
	input bpc_pkg::result_t                   result,
	input logic                               psel,
	input logic                               penable,
	input logic                               pwrite,
	input logic [bpc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input logic [bpc_pkg::APB_DATA_BITS-1:0]  pwdata,
	input logic [bpc_pkg::APB_DATA_BITS-1:0]  prdata,
	input logic                               pready
);
	import bpc_pkg::*;

	// A stalled result word stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	// A press edge restarts the hold timer, so no hold, click or pulse comes with it.
	a_edge_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.press_edge |->
			result.click_kind == KIND_NONE && result.hold_ms == 16'd0 && !result.long_pulse)
		else $error("press edge reported with hold, click or pulse");

	// A long press needs time past the threshold, so the hold time is never zero then.
	a_long_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.click_kind == KIND_LONG |-> result.hold_ms != 16'd0)
		else $error("long press reported with zero hold time");

	// Only the three defined click codes appear.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.click_kind == KIND_NONE || result.click_kind == KIND_SHORT
			|| result.click_kind == KIND_LONG)
		else $error("undefined click code");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

>>> tb/sv/press_checker.sv
// Checker for the button press classifier: watches both word channels and the APB port, predicts and compares.
`timescale 1ns / 1ps

module press_checker
	import bpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_ready,
	input  item_t                    item,
	input  logic                     result_valid,
	input  logic                     result_ready,
	input  result_t                  result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output int                       pending,
	output int                       failures
);

	// Shadow copy of the configuration registers.
	logic        idle_level;
	logic [15:0] debounce_delay;
	logic [15:0] long_press_ms;

	// Shadow copy of the press state.
	logic        prev_released;
	logic [31:0] last_sample_time;
	logic [31:0] hold_start_time;
	logic        press_armed;
	logic        long_fired;

	result_t     expected_results[$];
	int          fail_tally;

	// Works out the result of one sample and advances the shadow state.
	function automatic result_t classify_sample(input item_t w);
		logic        released;
		logic [31:0] span;
		result_t     r;
		released = (w.button_level == idle_level);
		r = '0;
		span = w.now_ms - last_sample_time;
		if (span >= {16'd0, debounce_delay}) begin
			if (!released && prev_released) begin
				r.press_edge = 1'b1;
				long_fired = 1'b0;
				press_armed = 1'b1;
				hold_start_time = w.now_ms;
			end else if (released && !prev_released && press_armed) begin
				press_armed = 1'b0;
				r.click_kind = KIND_SHORT;
			end else if (!released && !prev_released && press_armed) begin
				if ((w.now_ms - hold_start_time) > {16'd0, long_press_ms}) begin
					press_armed = 1'b0;
					r.click_kind = KIND_LONG;
				end
			end
			prev_released = released;
			last_sample_time = w.now_ms;
		end
		if (!released && !prev_released) begin
			span = w.now_ms - hold_start_time;
			r.hold_ms = (span > {16'd0, HOLD_MAX}) ? HOLD_MAX : span[15:0];
		end
		if (r.hold_ms > long_press_ms && !long_fired) begin
			r.long_pulse = 1'b1;
			long_fired = 1'b1;
		end
		if (w.restart_hold)
			hold_start_time = w.now_ms;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			idle_level = 1'b1;
			debounce_delay = '0;
			long_press_ms = LONG_PRESS_RESET;
			prev_released = 1'b1;
			last_sample_time = '0;
			hold_start_time = '0;
			press_armed = 1'b0;
			long_fired = 1'b0;
			expected_results.delete();
			fail_tally = 0;
			pending <= 0;
			failures <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no expectation waiting: %h", result);
					fail_tally++;
				end else begin
					e = expected_results.pop_front();
					if (result.press_edge !== e.press_edge) begin
						$error("press_edge: expected %0d, got %0d", e.press_edge, result.press_edge);
						fail_tally++;
					end
					if (result.click_kind !== e.click_kind) begin
						$error("click_kind: expected %0d, got %0d", e.click_kind, result.click_kind);
						fail_tally++;
					end
					if (result.hold_ms !== e.hold_ms) begin
						$error("hold_ms: expected %0d, got %0d", e.hold_ms, result.hold_ms);
						fail_tally++;
					end
					if (result.long_pulse !== e.long_pulse) begin
						$error("long_pulse: expected %0d, got %0d", e.long_pulse, result.long_pulse);
						fail_tally++;
					end
				end
			end
			if (item_valid && item_ready)
				expected_results.push_back(classify_sample(item));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_IDLE_LEVEL:     idle_level = pwdata[0];
					REG_DEBOUNCE_DELAY: debounce_delay = pwdata[15:0];
					REG_LONG_PRESS_MS:  long_press_ms = pwdata[15:0];
					default: ;
				endcase
			end
			pending <= expected_results.size();
			failures <= fail_tally;
		end
	end

endmodule

>>> tb/sv/tb.sv
// Top of the button press classifier testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
	import bpc_pkg::*;

	// The watchdog ends the run once this many cycles in a row pass with no word,
	// result or register write accepted. The longest legal quiet stretch is the
	// deliberate receiver hold-off.
	localparam int QUIET_LIMIT   = 5000;
	localparam int SQUEEZE_LEN   = 400;
	localparam int SQUEEZE_AT    = 300;
	localparam int RANDOM_WORDS  = 200;
	localparam int SETTLE_CYCLES = 4;

	logic                     clk;
	logic                     arst_n;
	logic                     item_valid;
	logic                     item_ready;
	item_t                    item;
	logic                     result_valid;
	logic                     result_ready;
	result_t                  result;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int   pending;
	int   failures;
	int   words_sent;
	int   settings_used;
	int   quiet_cycles;
	logic calm;
	logic squeezed;
	logic cur_idle;

	button_press_classifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	press_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pending      (pending),
		.failures     (failures)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap lengths are mostly zero or short, with an occasional long one. In a calm
	// phase neither side idles at all, so back-to-back traffic is exercised too.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one word after a random gap and holds it until the block takes it.
	// The task is entered and left on a rising edge, so each signal gets at most
	// one nonblocking assignment per time step.
	task automatic send_word(input item_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		words_sent++;
	endtask

	task automatic drive_sample(input logic [31:0] t, input logic lvl, input logic rs);
		item_t w;
		w.now_ms = t;
		w.button_level = lvl;
		w.restart_hold = rs;
		send_word(w);
	endtask

	// A write is a setup cycle followed by an access cycle; the extra edge at the
	// end keeps the next write's setup out of the step that drops psel.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only while the block is empty. The task waits for an edge first so
	// that the checker has counted the word accepted last, then the loop waits for the
	// last expected result and lets the two-stage pipeline settle.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic idle, input logic [15:0] gate,
			input logic [15:0] long_ms, input logic quiet);
		drain();
		write_reg(REG_IDLE_LEVEL, {31'd0, idle});
		write_reg(REG_DEBOUNCE_DELAY, {16'd0, gate});
		write_reg(REG_LONG_PRESS_MS, {16'd0, long_ms});
		cur_idle = idle;
		calm = quiet;
		settings_used++;
	endtask

	// Random press sequences: a timestamp that mostly creeps forward, sometimes
	// jumps far enough to wrap or to saturate the hold time, and a button that
	// alternates between runs of pressed and released samples with some bounce.
	// A small share of words is plain noise with every field random.
	task automatic run_presses(input int count);
		item_t       w;
		logic [31:0] t;
		logic        pressed;
		int          run_left;
		int          roll;
		t = $urandom;
		pressed = 1'b0;
		run_left = 0;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				w.now_ms = $urandom;
				w.button_level = 1'($urandom_range(0, 1));
				w.restart_hold = 1'($urandom_range(0, 1));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					t = t + $urandom_range(0, 40);
				else if (roll < 90)
					t = t + $urandom_range(40, 1500);
				else if (roll < 98)
					t = t + $urandom_range(1500, 70000);
				else
					t = t + $urandom;
				if (run_left == 0) begin
					pressed = ~pressed;
					run_left = $urandom_range(1, 30);
				end else begin
					run_left--;
				end
				w.now_ms = t;
				w.button_level = pressed ? ~cur_idle : cur_idle;
				if ($urandom_range(0, 19) == 0)
					w.button_level = ~w.button_level;
				w.restart_hold = ($urandom_range(0, 15) == 0);
			end
			send_word(w);
		end
	endtask

	// Receiver: one decision per edge. Once enough words have gone in it holds
	// result_ready low for a long stretch so that the block fills and stalls.
	initial begin
		int stall_left;
		stall_left = 0;
		squeezed = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!squeezed && words_sent >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				stall_left = SQUEEZE_LEN;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				if (stall_left > 0) begin
					result_ready <= 1'b0;
					stall_left--;
				end else begin
					result_ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: count edges at which nothing at all is accepted.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
				|| (psel && penable && pready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n = 1'b0;
		words_sent = 0;
		settings_used = 0;
		calm = 1'b0;
		cur_idle = 1'b1;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Only the debounce gate moves away from its reset value,
		// so that the early first samples after time zero are rejected while the
		// idle level (high) and the 1000 ms long-press threshold stay at reset.
		write_reg(REG_DEBOUNCE_DELAY, 32'd10);
		settings_used++;
		drive_sample(32'd3, 1'b0, 1'b0);          // too early after time zero
		drive_sample(32'd10, 1'b0, 1'b0);         // press edge
		drive_sample(32'd15, 1'b0, 1'b0);         // gated out, hold still reported
		drive_sample(32'd500, 1'b0, 1'b0);
		drive_sample(32'd1011, 1'b0, 1'b0);       // just past the threshold: long press
		drive_sample(32'd1100, 1'b0, 1'b1);       // pulse already fired, restart hold
		drive_sample(32'd1200, 1'b0, 1'b0);
		drive_sample(32'd1300, 1'b1, 1'b0);       // release after long: no click
		drive_sample(32'd1400, 1'b0, 1'b0);
		drive_sample(32'd1450, 1'b1, 1'b0);       // short click
		drive_sample(32'd1455, 1'b0, 1'b0);       // bounce inside the gate
		drive_sample(32'hFFFF_FFF0, 1'b0, 1'b0);  // press just before the wrap
		drive_sample(32'h0000_0010, 1'b0, 1'b0);  // held across the wrap
		drive_sample(32'h0002_0000, 1'b0, 1'b0);  // hold time saturates
		drive_sample(32'h0002_0100, 1'b1, 1'b1);
		drive_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
		drive_sample(32'h0000_0009, 1'b0, 1'b0);
		drive_sample(32'h5555_5555, 1'b1, 1'b0);
		drive_sample(32'hAAAA_AAAA, 1'b0, 1'b1);
		drive_sample(32'h0000_0000, 1'b1, 1'b1);
		run_presses(RANDOM_WORDS);

		// Random parts over a spread of settings, both idle levels and the
		// extremes of the gate and of the long-press threshold among them.
		apply_setting(1'b0, 16'd20, 16'd300, 1'b0);
		run_presses(RANDOM_WORDS);
		apply_setting(1'b1, 16'hFFFF, 16'd0, 1'b0);
		run_presses(RANDOM_WORDS);
		apply_setting(1'b0, 16'd0, 16'hFFFF, 1'b0);
		run_presses(RANDOM_WORDS);
		apply_setting(1'b1, 16'd0, 16'd1, 1'b1);
		run_presses(RANDOM_WORDS);

		drain();
		$display("Summary: %0d words checked under %0d register settings,", words_sent,
			settings_used);
		$display("directed edge cases plus random press sequences with noise and stalls.");
		if (failures == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
design/bpc_pkg.sv
design/button_press_classifier.sv
design/bpc_checker.sv
tb/sv/press_checker.sv
tb/sv/tb.sv
